/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the text console cursor engine.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tcce_pkg.sv */
// ---------------------------------------------------------------------------
// tcce_pkg
// Types, constants and helpers shared by the cursor engine modules.
// ---------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

  // Geometry defaults.
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 256;
  localparam logic [7:0] DEF_COLUMNS  = 8'd160;
  localparam logic [5:0] DEF_LAST_ROW = 6'd23;

  // Queue of cell commands produced by one byte.
  localparam int QDEPTH = 4;

  // Register indexes on the configuration port.
  localparam logic REG_COLUMNS  = 1'b0;
  localparam logic REG_LAST_ROW = 1'b1;

  // Character codes.
  localparam logic [7:0] CHAR_CTRL_MAX   = 8'd31;
  localparam logic [7:0] CHAR_LF         = 8'd10;
  localparam logic [7:0] CHAR_CR         = 8'd13;
  localparam logic [7:0] CHAR_DEL        = 8'd127;
  localparam logic [6:0] CHAR_UNDERSCORE = 7'h5F;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_ERASE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_ERROR = 2'd3
  } cmd_t;

  // One cell command; mem_col marks a column still to come from the row store.
  typedef struct packed {
    cmd_t       command;
    logic [6:0] glyph;
    logic [7:0] col;
    logic [5:0] row;
    logic       last;
    logic       mem_col;
  } cell_cmd_t;

  typedef struct packed {
    logic [7:0] col;
    logic [5:0] row;
    logic       in_str;
    logic       halted;
  } cursor_t;

  // Everything the decoder decides for one byte.
  typedef struct packed {
    cell_cmd_t [QDEPTH-1:0] cmds;
    logic [2:0]             count;
    cursor_t                next;
    logic                   wr_en;
    logic [5:0]             wr_row;
    logic [7:0]             wr_col;
    logic                   pend;
  } decode_t;

  function automatic cell_cmd_t mk_cmd(cmd_t command, logic [6:0] glyph,
                                       logic [7:0] col, logic [5:0] row,
                                       logic mem_col);
    cell_cmd_t c;
    c.command = command;
    c.glyph   = glyph;
    c.col     = col;
    c.row     = row;
    c.last    = 1'b0;
    c.mem_col = mem_col;
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/tcce_ram.sv */
// ---------------------------------------------------------------------------
// tcce_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tcce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/tcce_decode.sv */
// ---------------------------------------------------------------------------
// tcce_decode
// Turns one text byte and the cursor state into cell commands and next state.
// ---------------------------------------------------------------------------
`default_nettype none

module tcce_decode import tcce_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire cursor_t    cur,
  input  wire logic [7:0] columns,
  input  wire logic [5:0] last_row,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_string,
  output decode_t         dec
);

  logic       printable;
  logic       newline_chr;
  logic       del_chr;
  logic [7:0] col_inc;
  logic       wrap;
  logic       do_nl;
  logic       row_ok;
  logic       row_inc_ok;
  logic [2:0] n;
  logic [1:0] last_idx;

  assign printable   = (char_code > CHAR_CTRL_MAX) && (char_code < CHAR_DEL);
  assign newline_chr = (char_code == CHAR_LF) || (char_code == CHAR_CR);
  assign del_chr     = (char_code == CHAR_DEL);
  assign col_inc     = cur.col + 8'd1;
  assign wrap        = (col_inc >= columns) || ({1'b0, col_inc} >= 9'(MAX_COLS))
                       || (col_inc == 8'd0);
  assign row_ok      = {3'b000, cur.row} < 9'(MAX_ROWS);
  assign row_inc_ok  = ({3'b000, cur.row} + 9'd1) < 9'(MAX_ROWS);

  always_comb begin
    dec      = '0;
    dec.next = cur;
    n        = 3'd0;
    do_nl    = 1'b0;
    last_idx = 2'd0;
    if (!cur.halted) begin
      if (!cur.in_str) begin
        dec.cmds[n[1:0]] = mk_cmd(CMD_ERASE, 7'd0, cur.col, cur.row, 1'b0);
        n                = n + 3'd1;
        dec.next.in_str  = 1'b1;
      end
      if (printable) begin
        dec.cmds[n[1:0]] = mk_cmd(CMD_DRAW, char_code[6:0], cur.col, cur.row, 1'b0);
        n                = n + 3'd1;
        dec.wr_en        = row_ok;
        dec.wr_row       = cur.row;
        dec.wr_col       = cur.col;
        dec.next.col     = col_inc;
        do_nl            = wrap;
      end else if (newline_chr) begin
        do_nl = 1'b1;
      end else if (del_chr) begin
        if (cur.col != 8'd0) begin
          dec.next.col = cur.col - 8'd1;
          dec.wr_en    = row_ok;
          dec.wr_row   = cur.row;
          dec.wr_col   = cur.col - 8'd1;
        end else if (cur.row != 6'd0) begin
          // Column comes from the stored end of the previous row.
          dec.wr_en    = row_ok;
          dec.wr_row   = cur.row;
          dec.wr_col   = 8'd0;
          dec.next.row = cur.row - 6'd1;
          dec.next.col = 8'd0;
          dec.pend     = 1'b1;
        end
        dec.cmds[n[1:0]] = mk_cmd(CMD_ERASE, 7'd0, dec.next.col, dec.next.row, dec.pend);
        n                = n + 3'd1;
      end else begin
        dec.cmds[n[1:0]] = mk_cmd(CMD_ERROR, 7'd0, cur.col, cur.row, 1'b0);
        n                = n + 3'd1;
        dec.next.halted  = 1'b1;
      end

      if (do_nl) begin
        dec.next.col = 8'd0;
        if ((cur.row < last_row) && row_inc_ok) begin
          dec.next.row = cur.row + 6'd1;
        end else begin
          dec.cmds[n[1:0]] = mk_cmd(CMD_CLEAR, 7'd0, 8'd0, last_row, 1'b0);
          n                = n + 3'd1;
          dec.next.row     = 6'd0;
        end
      end

      if (end_of_string && !dec.next.halted) begin
        dec.cmds[n[1:0]] = mk_cmd(CMD_DRAW, CHAR_UNDERSCORE, dec.next.col,
                                  dec.next.row, dec.pend);
        n                = n + 3'd1;
        dec.next.in_str  = 1'b0;
      end

      last_idx = n[1:0] - 2'd1;
      if (n != 3'd0) begin
        dec.cmds[last_idx].last = 1'b1;
      end
    end
    dec.count = n;
  end

endmodule

`default_nettype wire

/* hdl/text_console_cursor_engine_top.sv */
// ---------------------------------------------------------------------------
// text_console_cursor_engine_top
// Cursor engine for a character-cell text console.
// ---------------------------------------------------------------------------
// Usage: text bytes enter on the in_ channel, one byte per beat, with
// in_end_of_string marking the final byte of a string. Each byte yields zero
// to four cell commands on the out_ channel, one per beat, the final one
// flagged by out_last. A beat moves when valid is high and stall is low.
// The first command of a byte goes from the command queue register to the
// output register after the byte is accepted. The queue holds one byte's
// commands and drains one entry per cycle while the output does not stall;
// a delete that steps back to the previous row first holds the queue and the
// input while the stored end column is read from the row RAM.
// A byte is taken in the same cycle as the last queued command moves to the
// output register, so a waiting result never blocks the input by itself.
// Reset (rst_n low, synchronous) homes the cursor, leaves string and halt
// flags clear, loads 160 columns and last row 23, and invalidates every row
// end entry at once through per-row valid bits; no clearing pass is needed.
// When the receiver stalls, the output register holds its command, the queue
// stops draining and in_stall is high while it holds any command. After an error
// command the engine accepts and discards bytes until reset.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine_top import tcce_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Configuration port
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wr_data,
  // Input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_end_of_string,
  // Result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_command,
  output logic [6:0]      out_glyph_code,
  output logic [7:0]      out_cell_col,
  output logic [5:0]      out_cell_row,
  output logic            out_last
);

  localparam int ROW_AW = $clog2(MAX_ROWS);

  // Configuration registers.
  logic [7:0] columns_r;
  logic [5:0] last_row_r;

  // Cursor state and the wait for a row end read.
  cursor_t cur_r;
  logic    pend_r;
  logic    rd_valid_r;

  // Per-row valid bits for the row end RAM; an invalid row reads as zero.
  logic [MAX_ROWS-1:0] row_valid_r;

  // Command queue for the byte in progress and the output register.
  cell_cmd_t [QDEPTH-1:0] q_r;
  logic [1:0]             head_r;
  logic [2:0]             count_r;
  cell_cmd_t              out_r;
  logic                   out_valid_r;

  decode_t           dec;
  logic              accept;
  logic              pop_en;
  logic [ROW_AW-1:0] ram_waddr;
  logic [ROW_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic [7:0]        end_col;

  tcce_decode #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_decode (
    .cur           (cur_r),
    .columns       (columns_r),
    .last_row      (last_row_r),
    .char_code     (in_char_code),
    .end_of_string (in_end_of_string),
    .dec           (dec)
  );

  // The read always targets the row above the cursor. Writes from the same
  // byte go to the cursor row itself, so a read never meets a write in flight.
  assign ram_waddr = ROW_AW'(dec.wr_row);
  assign ram_raddr = ROW_AW'(cur_r.row - 6'd1);

  tcce_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROWS)
  ) u_row_end_ram (
    .clk   (clk),
    .we    (accept && dec.wr_en),
    .waddr (ram_waddr),
    .wdata (dec.wr_col),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign end_col = rd_valid_r ? ram_rdata : 8'd0;

  // The queue drains into the output register whenever that register is free
  // or being emptied, except in the cycle that patches the stored column in.
  assign pop_en   = (count_r != 3'd0) && !pend_r && (!out_valid_r || !out_stall);
  assign in_stall = pend_r || !((count_r == 3'd0) || ((count_r == 3'd1) && pop_en));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r   <= DEF_COLUMNS;
      last_row_r  <= DEF_LAST_ROW;
      cur_r       <= '0;
      pend_r      <= 1'b0;
      row_valid_r <= '0;
      head_r      <= 2'd0;
      count_r     <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_COLUMNS:  columns_r  <= cfg_wr_data;
          REG_LAST_ROW: last_row_r <= cfg_wr_data[5:0];
          default: ;
        endcase
      end

      if (accept) begin
        cur_r   <= dec.next;
        pend_r  <= dec.pend;
        head_r  <= 2'd0;
        count_r <= dec.count;
        if (dec.wr_en) begin
          row_valid_r[ram_waddr] <= 1'b1;
        end
      end else begin
        if (pop_en) begin
          head_r  <= head_r + 2'd1;
          count_r <= count_r - 3'd1;
        end
        if (pend_r) begin
          cur_r.col <= end_col;
          pend_r    <= 1'b0;
        end
      end

      if (pop_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: queue contents, read-side valid and output command.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r        <= dec.cmds;
      rd_valid_r <= row_valid_r[ram_raddr];
    end else if (pend_r) begin
      for (int i = 0; i < QDEPTH; i++) begin
        if (q_r[i].mem_col) begin
          q_r[i].col <= end_col;
        end
      end
    end
    if (pop_en) begin
      out_r <= q_r[head_r];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_command    = out_r.command;
  assign out_glyph_code = out_r.glyph;
  assign out_cell_col   = out_r.col;
  assign out_cell_row   = out_r.row;
  assign out_last       = out_r.last;

endmodule

`default_nettype wire

/* hdl/tcce_checker.sv */
// ---------------------------------------------------------------------------
// tcce_checker
// Port-level checks on the result channel of the cursor engine.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcce_checker import tcce_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_command,
  input wire logic [6:0] out_glyph_code,
  input wire logic [7:0] out_cell_col,
  input wire logic       out_last
);

  `TCCE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result beat dropped while stalled")
  `TCCE_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_command) && $stable(out_cell_col), "stalled result changed")
  `TCCE_ASSERT_SAME(a_error_last, clk, rst_n, out_valid && (out_command == CMD_ERROR), out_last, "error command not final beat of its byte")
  `TCCE_ASSERT_SAME(a_clear_shape, clk, rst_n, out_valid && (out_command == CMD_CLEAR), (out_cell_col == 8'd0) && (out_glyph_code == 7'd0), "clear command with column or glyph set")

endmodule

bind text_console_cursor_engine_top tcce_checker u_tcce_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_command    (out_command),
  .out_glyph_code (out_glyph_code),
  .out_cell_col   (out_cell_col),
  .out_last       (out_last)
);

`default_nettype wire
